// File: rtl/ctok_pkg.sv
// ----------------------------------------------------------------------------
// ctok_pkg
// Shared types, character codes and classification functions for the
// C source tokenizer.
// ----------------------------------------------------------------------------
package ctok_pkg;

  localparam int unsigned RunMax = 5;
  localparam int unsigned CntW   = $clog2(RunMax + 1);

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_QMARK  = 8'h3f;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_CARET  = 8'h5e;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_PIPE   = 8'h7c;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_TILDE  = 8'h7e;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_STRING  = 2'd1,
    MODE_COMMENT = 2'd2
  } lex_mode_t;

  typedef struct packed {
    logic                         load;
    logic [CntW-1:0]              count;
    logic [RunMax-1:0][7:0]       bytes;
  } lex_emit_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
  endfunction

  function automatic logic is_punct(logic [7:0] c);
    return (c == CH_HASH) || (c == CH_LPAREN) || (c == CH_LBRACK) ||
           (c == CH_LBRACE) || (c == CH_COLON) || (c == CH_RPAREN) ||
           (c == CH_RBRACK) || (c == CH_RBRACE) || (c == CH_SEMI) ||
           (c == CH_DOT) || (c == CH_COMMA) || (c == CH_STAR);
  endfunction

  function automatic logic is_op(logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_EQ) || (c == CH_AMP) ||
           (c == CH_PIPE) || (c == CH_CARET) || (c == CH_PCT) || (c == CH_BANG) ||
           (c == CH_QMARK) || (c == CH_LT) || (c == CH_GT) || (c == CH_TILDE);
  endfunction

  function automatic logic takes_eq(logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
           (c == CH_SLASH) || (c == CH_GT) || (c == CH_LT) || (c == CH_BANG);
  endfunction

  function automatic lex_emit_t push(lex_emit_t e, logic [7:0] v);
    lex_emit_t r;
    r = e;
    r.bytes[r.count] = v;
    r.count = r.count + CntW'(1);
    return r;
  endfunction

endpackage

// File: rtl/ctok_if.sv
// ----------------------------------------------------------------------------
// ctok_if
// Valid/ready channels for source bytes in and token bytes out.
// ----------------------------------------------------------------------------
interface ctok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       line_end;

  modport source (output valid, output source_byte, output line_end, input ready);
  modport sink   (input valid, input source_byte, input line_end, output ready);
endinterface

interface ctok_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

// File: rtl/ctok_lexer.sv
// ----------------------------------------------------------------------------
// ctok_lexer
// Lexer state registers and the single-pass byte classifier that builds the
// run of output bytes for one request.
// ----------------------------------------------------------------------------
module ctok_lexer
  import ctok_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] src,
  input  logic       le,
  output lex_emit_t  emit
);

  lex_mode_t  mode_r, mode_nxt;
  logic       lwb_r, lwb_nxt;
  logic [7:0] held_r, held_nxt;
  logic       hv_r, hv_nxt;
  logic       bs_r, bs_nxt;
  logic       star_r, star_nxt;

  always_comb begin
    lex_emit_t e;
    logic      do_norm;
    e        = '0;
    do_norm  = 1'b0;
    mode_nxt = mode_r;
    lwb_nxt  = lwb_r;
    held_nxt = held_r;
    hv_nxt   = hv_r;
    bs_nxt   = bs_r;
    star_nxt = star_r;

    if (mode_r == MODE_STRING) begin
      if ((src == CH_QUOTE) && !bs_r) mode_nxt = MODE_NORMAL;
      e       = push(e, src);
      lwb_nxt = (src == CH_LF);
      bs_nxt  = (src == CH_BSLASH) && !bs_r;
    end else if (mode_r == MODE_COMMENT) begin
      if (star_r && (src == CH_SLASH)) begin
        mode_nxt = MODE_NORMAL;
        star_nxt = 1'b0;
      end else begin
        star_nxt = (src == CH_STAR);
      end
    end else if (hv_r) begin
      hv_nxt   = 1'b0;
      held_nxt = '0;
      if ((held_r == CH_SLASH) && (src == CH_STAR)) begin
        mode_nxt = MODE_COMMENT;
        star_nxt = 1'b0;
      end else if ((held_r != CH_SLASH) &&
                   ((src == held_r) || ((src == CH_EQ) && takes_eq(held_r)))) begin
        if (!lwb_nxt) e = push(e, CH_LF);
        e       = push(e, held_r);
        e       = push(e, src);
        e       = push(e, CH_LF);
        lwb_nxt = 1'b1;
      end else begin
        if (!lwb_nxt) e = push(e, CH_LF);
        e       = push(e, held_r);
        e       = push(e, CH_LF);
        lwb_nxt = 1'b1;
        do_norm = 1'b1;
      end
    end else begin
      do_norm = 1'b1;
    end

    if (do_norm) begin
      if (is_space(src)) begin
        if (!lwb_nxt) e = push(e, CH_LF);
        lwb_nxt = 1'b1;
      end else if (is_punct(src)) begin
        if (!lwb_nxt) e = push(e, CH_LF);
        e       = push(e, src);
        e       = push(e, CH_LF);
        lwb_nxt = 1'b1;
      end else if (src == CH_QUOTE) begin
        if (!lwb_nxt) e = push(e, CH_LF);
        e        = push(e, src);
        lwb_nxt  = 1'b0;
        mode_nxt = MODE_STRING;
        bs_nxt   = 1'b0;
      end else if (is_op(src) || (src == CH_SLASH)) begin
        if (le) begin
          if (!lwb_nxt) e = push(e, CH_LF);
          e       = push(e, src);
          e       = push(e, CH_LF);
          lwb_nxt = 1'b1;
        end else begin
          held_nxt = src;
          hv_nxt   = 1'b1;
        end
      end else begin
        e       = push(e, src);
        lwb_nxt = 1'b0;
      end
    end

    if (le) begin
      if (mode_nxt == MODE_COMMENT) begin
        star_nxt = 1'b0;
      end else if ((mode_nxt != MODE_STRING) && !hv_nxt) begin
        if (!lwb_nxt) e = push(e, CH_LF);
        lwb_nxt = 1'b1;
      end
    end

    e.load = accept;
    emit   = e;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      lwb_r  <= 1'b0;
      held_r <= '0;
      hv_r   <= 1'b0;
      bs_r   <= 1'b0;
      star_r <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      lwb_r  <= lwb_nxt;
      held_r <= held_nxt;
      hv_r   <= hv_nxt;
      bs_r   <= bs_nxt;
      star_r <= star_nxt;
    end
  end

endmodule

// File: rtl/ctok_outbuf.sv
// ----------------------------------------------------------------------------
// ctok_outbuf
// Result register: holds one run of token bytes and shifts it out one byte
// per transfer, flagging the last byte of the run.
// ----------------------------------------------------------------------------
module ctok_outbuf
  import ctok_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  lex_emit_t    emit,
  output logic         take_ok,
  ctok_out_if.source   out_rsp
);

  logic [CntW-1:0]        cnt_r, cnt_nxt;
  logic [RunMax-1:0][7:0] bytes_r, bytes_nxt;
  logic                   pop;

  assign out_rsp.valid    = (cnt_r != '0);
  assign out_rsp.out_byte = bytes_r[0];
  assign out_rsp.run_last = (cnt_r == CntW'(1));
  assign pop              = out_rsp.valid && out_rsp.ready;
  assign take_ok          = (cnt_r == '0) || ((cnt_r == CntW'(1)) && out_rsp.ready);

  always_comb begin
    cnt_nxt   = cnt_r;
    bytes_nxt = bytes_r;
    if (pop) begin
      cnt_nxt   = cnt_r - CntW'(1);
      bytes_nxt = {8'h00, bytes_r[RunMax-1:1]};
    end
    if (emit.load) begin
      cnt_nxt   = emit.count;
      bytes_nxt = emit.bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
  end

endmodule

// File: rtl/c_source_tokenizer_top.sv
// ----------------------------------------------------------------------------
// c_source_tokenizer_top
// Latency: a request's first output byte is valid the cycle after acceptance.
// Flow: a request produces k output bytes (k is at most 5); the next request
// is taken in the cycle the last byte of the current run is taken, set by the
// single result register.
// Reset: synchronous active-low rst_n clears lexer state and empties the
// result register; no clearing pass.
// ----------------------------------------------------------------------------
module c_source_tokenizer_top
  import ctok_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ctok_in_if.sink     in_req,
  ctok_out_if.source  out_rsp
);

  logic      take_ok;
  logic      accept;
  lex_emit_t emit;

  assign in_req.ready = take_ok;
  assign accept       = in_req.valid && take_ok;

  ctok_lexer u_lexer (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .src    (in_req.source_byte),
    .le     (in_req.line_end),
    .emit   (emit)
  );

  ctok_outbuf u_outbuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .emit    (emit),
    .take_ok (take_ok),
    .out_rsp (out_rsp)
  );

endmodule
